// ===== rtl/lgr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers of the boosting loss/gradient block.
// No dependencies; every other file imports this package.
package lgr_pkg;

  typedef enum logic [1:0] {
    MODE_SQUARED  = 2'd0,
    MODE_SOFTMAX  = 2'd1,
    MODE_WSOFTMAX = 2'd2,
    MODE_CSLOG    = 2'd3
  } loss_mode_e;

  localparam logic REG_LOSS_MODE  = 1'b0;
  localparam logic REG_BATCH_SIZE = 1'b1;

  localparam logic KIND_GRAD = 1'b0;
  localparam logic KIND_LOSS = 1'b1;

  localparam logic signed [24:0] EXP_ARG_CAP = 25'sd720896;   // 11.0 in Q.16
  localparam logic [16:0]        LOG2E_Q16   = 17'd94548;
  localparam logic [15:0]        LN2_Q16     = 16'd45426;
  localparam logic signed [63:0] ONE_Q16     = 64'sd65536;
  localparam logic signed [63:0] ONE_Q32     = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] ONE_Q48     = 64'sh0001_0000_0000_0000;

  typedef struct packed {
    logic signed [23:0] activation;
    logic signed [23:0] class_weight;
    logic        [4:0]  true_class;
    logic               last_of_sample;
    logic               last_of_batch;
  } in_item_t;

  typedef struct packed {
    logic               out_kind;
    logic        [4:0]  class_index;
    logic signed [23:0] out_value;
    logic               last_result;
  } out_item_t;

  // one queued word: element payload plus its end-of-sample classification
  typedef struct packed {
    logic signed [23:0] activation;
    logic signed [23:0] class_weight;
    logic        [4:0]  true_class;
    logic               eos;
    logic               eob;
  } q_item_t;

  typedef struct packed {
    loss_mode_e  loss_mode;
    logic [15:0] batch_size;
  } cfg_t;

  // 2^(i/16) in Q.16
  function automatic logic [17:0] pow2_tab(input logic [4:0] i);
    logic [17:0] r;
    case (i)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      5'd16:   r = 18'd131072;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  // divide by 2^16, truncating toward zero
  function automatic logic signed [63:0] tdiv16(input logic signed [63:0] x);
    logic signed [63:0] nx;
    nx = -x;
    return x[63] ? -(nx >>> 16) : (x >>> 16);
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lgr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, marks sample and batch ends, and queues them.
// Depends on lgr_pkg.
module lgr_front
  import lgr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     pop_i,
  output logic     q_valid_o,
  output q_item_t  q_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  q_item_t           buf_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic              push, pop;
  q_item_t           entry;

  assign in_ready_o = (count_q != (PtrW + 1)'(Depth));
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = buf_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && q_valid_o;

  // batch end also closes the sample
  always_comb begin
    entry.activation   = in_data_i.activation;
    entry.class_weight = in_data_i.class_weight;
    entry.true_class   = in_data_i.true_class;
    entry.eob          = in_data_i.last_of_batch;
    entry.eos          = in_data_i.last_of_sample | in_data_i.last_of_batch;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/lgr_div.sv =====
`timescale 1ns / 1ps
// Signed-by-positive 64-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on lgr_pkg.
module lgr_div
  import lgr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic        [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] rem_q, dvd_q, den_q;
  logic        neg_q;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign fits   = (rem_sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      den_q <= den_i;
      neg_q <= num_i[63];
    end else if (busy_q) begin
      rem_q <= fits ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
      dvd_q <= {dvd_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/lgr_back.sv =====
`timescale 1ns / 1ps
// Back end: buffers a sample, runs the two passes with a shared multiplier,
// exp/log datapath and the divider, and holds the output register. Uses lgr_pkg, lgr_div.
module lgr_back
  import lgr_pkg::*;
#(
  parameter int unsigned MaxClasses = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  q_item_t   q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned IdxW = $clog2(MaxClasses);
  localparam int unsigned CntW = $clog2(MaxClasses + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxClasses);

  typedef enum logic [27:0] {
    S_IDLE      = 28'h0000001,
    S_REF       = 28'h0000002,
    S_REF2      = 28'h0000004,
    S_P1_RD     = 28'h0000008,
    S_P1_A      = 28'h0000010,
    S_P1_E      = 28'h0000020,
    S_P1_T      = 28'h0000040,
    S_P1_ACC    = 28'h0000080,
    S_P1_END    = 28'h0000100,
    S_LN_NORM   = 28'h0000200,
    S_LN_SQ     = 28'h0000400,
    S_LN_SQ2    = 28'h0000800,
    S_LN_MUL    = 28'h0001000,
    S_LN_FIN    = 28'h0002000,
    S_INV_WAIT  = 28'h0004000,
    S_BATCH     = 28'h0008000,
    S_P2_RD     = 28'h0010000,
    S_P2_A      = 28'h0020000,
    S_P2_DIV1   = 28'h0040000,
    S_P2_LW     = 28'h0080000,
    S_P2_LE     = 28'h0100000,
    S_P2_G      = 28'h0200000,
    S_P2_BS     = 28'h0400000,
    S_P2_DIV2   = 28'h0800000,
    S_P2_OUT    = 28'h1000000,
    S_LOSS_DIV  = 28'h2000000,
    S_LOSS_WAIT = 28'h4000000,
    S_LOSS_OUT  = 28'h8000000
  } state_e;

  state_e state_q, state_d;

  // sample buffers
  logic signed [23:0] score_mem  [MaxClasses];
  logic signed [23:0] weight_mem [MaxClasses];
  logic signed [47:0] term_mem   [MaxClasses];
  logic signed [23:0] rd_score_q, rd_weight_q;
  logic signed [47:0] rd_term_q;
  logic [IdxW-1:0]    rd_addr;
  logic               buf_we, term_we;
  logic signed [47:0] term_wd;

  logic [CntW-1:0]    cnt_q, cnt_d, n_q, n_d, j_q, j_d, j_inc;
  logic [4:0]         label_q, label_d;
  logic               eob_q, eob_d;
  logic signed [23:0] amax_q, amax_d, ref_q, ref_d, inv_q, inv_d, val_q, val_d;
  logic signed [63:0] tot_q, tot_d, g_q, g_d, prod_q;
  logic signed [47:0] sloss_q, sloss_d, sum_q, sum_d;
  logic [63:0]        v_q, v_d;
  logic [5:0]         p_q, p_d;
  logic [30:0]        m_q, m_d;
  logic [15:0]        bits_q, bits_d;
  logic [3:0]         k_q, k_d;
  logic [32:0]        e_q, e_d;
  logic signed [31:0] lw_q, lw_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic signed [33:0] op_a, op_b;

  logic               div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [63:0]        div_den;

  // combinational helpers
  loss_mode_e         mode;
  logic [63:0]        bs64;
  logic signed [23:0] a, w;
  logic signed [24:0] d_sum, x_sm, x_cs, x_cap;
  logic               has_lab, is_lab, out_free;
  logic signed [10:0] e_n, e_nneg;
  logic [17:0]        t0, t1, mant;
  logic [29:0]        interp;
  logic [63:0]        e_full;
  logic [31:0]        sq32;
  logic signed [22:0] l2;
  logic signed [63:0] ln64;
  logic signed [48:0] sum_ext;

  assign mode    = cfg_i.loss_mode;
  assign bs64    = (cfg_i.batch_size == '0) ? 64'd1 : 64'(cfg_i.batch_size);
  assign a       = rd_score_q;
  assign w       = rd_weight_q;
  assign d_sum   = {a[23], a} + {w[23], w};
  assign x_sm    = {a[23], a} - {amax_q[23], amax_q};
  assign x_cs    = {a[23], a} - {ref_q[23], ref_q};
  assign x_cap   = (x_cs > EXP_ARG_CAP) ? EXP_ARG_CAP : x_cs;
  assign has_lab = ({1'b0, label_q} < 6'(n_q));
  assign is_lab  = has_lab && (6'(j_q) == {1'b0, label_q});
  assign j_inc   = CntW'(j_q + 1'b1);
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_addr = (state_q == S_REF) ? label_q[IdxW-1:0] : j_q[IdxW-1:0];

  // exp: split the product into integer and fraction of log2, then interpolate
  assign e_n    = prod_q[42:32];
  assign e_nneg = -e_n;
  assign t0     = pow2_tab({1'b0, prod_q[31:28]});
  assign t1     = pow2_tab(5'({1'b0, prod_q[31:28]} + 5'd1));
  assign interp = 30'(t1 - t0) * 30'(prod_q[27:16]);
  assign mant   = t0 + interp[29:12];
  always_comb begin
    if (!e_n[10]) begin
      e_full = 64'(mant) << e_n[4:0];
    end else if (e_n <= -11'sd32) begin
      e_full = '0;
    end else begin
      e_full = 64'(mant) >> e_nneg[4:0];
    end
  end

  assign sq32    = prod_q[61:30];
  assign l2      = $signed({7'({1'b0, p_q} - 7'd32), bits_q});
  assign ln64    = tdiv16(prod_q);
  assign sum_ext = {sum_q[47], sum_q} + {sloss_q[47], sloss_q};

  lgr_div u_lgr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    j_d         = j_q;
    label_d     = label_q;
    eob_d       = eob_q;
    amax_d      = amax_q;
    ref_d       = ref_q;
    inv_d       = inv_q;
    val_d       = val_q;
    tot_d       = tot_q;
    g_d         = g_q;
    sloss_d     = sloss_q;
    sum_d       = sum_q;
    v_d         = v_q;
    p_d         = p_q;
    m_d         = m_q;
    bits_d      = bits_q;
    k_d         = k_q;
    e_d         = e_q;
    lw_d        = lw_q;
    out_data_d  = out_data_q;
    out_valid_d = (out_valid_q && !out_ready_i);
    q_pop_o     = 1'b0;
    buf_we      = 1'b0;
    term_we     = 1'b0;
    term_wd     = prod_q[47:0];
    op_a        = '0;
    op_b        = '0;
    div_start   = 1'b0;
    div_num     = g_q;
    div_den     = bs64;

    case (state_q)
      S_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          n_d = cnt_q;
          if (cnt_q < CntMax) begin
            buf_we = 1'b1;
            cnt_d  = CntW'(cnt_q + 1'b1);
            n_d    = CntW'(cnt_q + 1'b1);
            if (cnt_q == '0 || q_data_i.activation > amax_q) begin
              amax_d = q_data_i.activation;
            end
          end
          if (q_data_i.eos) begin
            cnt_d   = '0;
            label_d = q_data_i.true_class;
            eob_d   = q_data_i.eob;
            state_d = S_REF;
          end
        end
      end
      S_REF: state_d = S_REF2;
      S_REF2: begin
        ref_d   = has_lab ? rd_score_q : 24'sd0;
        j_d     = '0;
        tot_d   = (mode == MODE_CSLOG) ? ONE_Q32 : 64'sd0;
        state_d = S_P1_RD;
      end
      S_P1_RD: state_d = S_P1_A;
      S_P1_A: begin
        if (mode == MODE_SQUARED) begin
          op_a    = 34'(d_sum);
          op_b    = 34'(d_sum);
          state_d = S_P1_ACC;
        end else begin
          op_a    = (mode == MODE_CSLOG) ? 34'(x_cap) : 34'(x_sm);
          op_b    = $signed({17'd0, LOG2E_Q16});
          state_d = S_P1_E;
        end
      end
      S_P1_E: begin
        e_d     = e_full[32:0];
        state_d = S_P1_T;
      end
      S_P1_T: begin
        op_a    = $signed({1'b0, e_q});
        op_b    = (mode == MODE_SOFTMAX) ? 34'(ONE_Q16) : 34'(w);
        state_d = S_P1_ACC;
      end
      S_P1_ACC: begin
        term_we = 1'b1;
        term_wd = (mode == MODE_CSLOG) ? $signed({15'd0, e_q}) : prod_q[47:0];
        if (mode != MODE_CSLOG || !is_lab) begin
          tot_d = tot_q + prod_q;
        end
        j_d     = j_inc;
        state_d = (j_inc == n_q) ? S_P1_END : S_P1_RD;
      end
      S_P1_END: begin
        if (mode == MODE_SQUARED) begin
          sloss_d = 48'(tot_q >>> 16);
          state_d = S_BATCH;
        end else begin
          // sum floor of one LSB
          tot_d   = (tot_q < 64'sd1) ? 64'sd1 : tot_q;
          v_d     = (tot_q < 64'sd1) ? 64'd1 : 64'(tot_q);
          p_d     = 6'd63;
          state_d = S_LN_NORM;
        end
      end
      S_LN_NORM: begin
        if (v_q[63]) begin
          m_d     = v_q[63:33];
          k_d     = '0;
          bits_d  = '0;
          state_d = S_LN_SQ;
        end else begin
          v_d = {v_q[62:0], 1'b0};
          p_d = p_q - 1'b1;
        end
      end
      S_LN_SQ: begin
        op_a    = $signed({3'd0, m_q});
        op_b    = $signed({3'd0, m_q});
        state_d = S_LN_SQ2;
      end
      S_LN_SQ2: begin
        if (sq32[31]) begin
          m_d    = sq32[31:1];
          bits_d = {bits_q[14:0], 1'b1};
        end else begin
          m_d    = sq32[30:0];
          bits_d = {bits_q[14:0], 1'b0};
        end
        k_d     = k_q + 1'b1;
        state_d = (k_q == 4'd15) ? S_LN_MUL : S_LN_SQ;
      end
      S_LN_MUL: begin
        op_a    = 34'(l2);
        op_b    = $signed({18'd0, LN2_Q16});
        state_d = S_LN_FIN;
      end
      S_LN_FIN: begin
        if (mode == MODE_CSLOG) begin
          sloss_d   = ln64[47:0];
          div_start = 1'b1;
          div_num   = ONE_Q48;
          div_den   = 64'(tot_q);
          state_d   = S_INV_WAIT;
        end else begin
          sloss_d = ln64[47:0] + 48'(amax_q) - 48'(ref_q);
          state_d = S_BATCH;
        end
      end
      S_INV_WAIT: begin
        if (div_done) begin
          inv_d   = clamp24(div_quo);
          state_d = S_BATCH;
        end
      end
      S_BATCH: begin
        if (sum_ext > 49'sh0_7FFF_FFFF_FFFF) begin
          sum_d = 48'sh7FFF_FFFF_FFFF;
        end else if (sum_ext < -49'sh0_8000_0000_0000) begin
          sum_d = 48'sh8000_0000_0000;
        end else begin
          sum_d = sum_ext[47:0];
        end
        j_d     = '0;
        state_d = S_P2_RD;
      end
      S_P2_RD: state_d = S_P2_A;
      S_P2_A: begin
        if (mode == MODE_SQUARED) begin
          g_d     = 64'(d_sum);
          state_d = S_P2_BS;
        end else if (mode == MODE_CSLOG) begin
          if (is_lab) begin
            g_d     = 64'(inv_q) - ONE_Q16;
            state_d = S_P2_BS;
          end else begin
            op_a    = 34'(inv_q);
            op_b    = 34'(w);
            state_d = S_P2_LW;
          end
        end else begin
          div_start = 1'b1;
          div_num   = {rd_term_q, 16'h0000};
          div_den   = 64'(tot_q);
          state_d   = S_P2_DIV1;
        end
      end
      S_P2_DIV1: begin
        if (div_done) begin
          g_d     = div_quo - (is_lab ? ONE_Q16 : 64'sd0);
          state_d = S_P2_BS;
        end
      end
      S_P2_LW: begin
        lw_d    = ln64[31:0];
        state_d = S_P2_LE;
      end
      S_P2_LE: begin
        op_a    = 34'(lw_q);
        op_b    = $signed({1'b0, rd_term_q[32:0]});
        state_d = S_P2_G;
      end
      S_P2_G: begin
        g_d     = ln64;
        state_d = S_P2_BS;
      end
      S_P2_BS: begin
        div_start = 1'b1;
        state_d   = S_P2_DIV2;
      end
      S_P2_DIV2: begin
        if (div_done) begin
          val_d   = clamp24(div_quo);
          state_d = S_P2_OUT;
        end
      end
      S_P2_OUT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.out_kind     = KIND_GRAD;
          out_data_d.class_index  = 5'(j_q);
          out_data_d.out_value    = val_q;
          out_data_d.last_result  = (j_inc == n_q) && !eob_q;
          j_d                     = j_inc;
          if (j_inc == n_q) begin
            state_d = eob_q ? S_LOSS_DIV : S_IDLE;
          end else begin
            state_d = S_P2_RD;
          end
        end
      end
      S_LOSS_DIV: begin
        div_start = 1'b1;
        div_num   = 64'(sum_q);
        state_d   = S_LOSS_WAIT;
      end
      S_LOSS_WAIT: begin
        if (div_done) begin
          val_d   = clamp24(div_quo);
          state_d = S_LOSS_OUT;
        end
      end
      S_LOSS_OUT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.out_kind     = KIND_LOSS;
          out_data_d.class_index  = '0;
          out_data_d.out_value    = val_q;
          out_data_d.last_result  = 1'b1;
          sum_d                   = '0;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // buffers: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      score_mem[cnt_q[IdxW-1:0]]  <= q_data_i.activation;
      weight_mem[cnt_q[IdxW-1:0]] <= q_data_i.class_weight;
    end
    if (term_we) begin
      term_mem[j_q[IdxW-1:0]] <= term_wd;
    end
    rd_score_q  <= score_mem[rd_addr];
    rd_weight_q <= weight_mem[rd_addr];
    rd_term_q   <= term_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= 64'(op_a * op_b);
    n_q        <= n_d;
    label_q    <= label_d;
    eob_q      <= eob_d;
    amax_q     <= amax_d;
    ref_q      <= ref_d;
    val_q      <= val_d;
    tot_q      <= tot_d;
    g_q        <= g_d;
    sloss_q    <= sloss_d;
    v_q        <= v_d;
    p_q        <= p_d;
    m_q        <= m_d;
    bits_q     <= bits_d;
    k_q        <= k_d;
    e_q        <= e_d;
    lw_q       <= lw_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      sum_q       <= '0;
      inv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      sum_q       <= sum_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/multimode_boosting_loss_gradient.sv =====
`timescale 1ns / 1ps
// Top level of the boosting loss/gradient block: configuration registers,
// front queue and back end. Depends on lgr_pkg, lgr_front, lgr_back.
//
// Each class element is accepted into a four-deep queue, and the back end
// stores it in its sample buffer. When a sample of n classes ends, the back
// end works on it alone: the first pass over the n classes; outside squared
// mode the logarithm (normalize with up to 63 shift steps plus 16 squaring
// steps) and, in cost-sensitive mode, a reciprocal; then per class a gradient
// divided by the batch size, in the softmax modes after a division by the sum,
// all on the shared one-bit-per-cycle 64-bit divider. A batch end adds a mean
// loss division. Input words queue during this work until the queue is full.
module multimode_boosting_loss_gradient
  import lgr_pkg::*;
#(
  parameter int unsigned MaxClasses = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  q_item_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss_mode  <= MODE_SOFTMAX;
      cfg_q.batch_size <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOSS_MODE:  cfg_q.loss_mode  <= loss_mode_e'(cfg_data_i[1:0]);
        REG_BATCH_SIZE: cfg_q.batch_size <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lgr_front u_lgr_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pop_i      (q_pop),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data)
  );

  lgr_back #(
    .MaxClasses (MaxClasses)
  ) u_lgr_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/lgr_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the boosting loss/gradient block, bound to the top level.
// Depends on lgr_pkg.
module lgr_chk
  import lgr_pkg::*;
#(
  parameter int unsigned MaxClasses = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  a_loss_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_LOSS
      |-> out_data_o.last_result && out_data_o.class_index == 5'd0)
    else $error("loss word not last or carries a class");

  a_grad_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == KIND_GRAD
      |-> 32'(out_data_o.class_index) < MaxClasses)
    else $error("gradient class beyond buffer depth");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind multimode_boosting_loss_gradient lgr_chk #(
  .MaxClasses (MaxClasses)
) u_lgr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
